// ----- rtl/rsa_modexp_decrypt_unit_defines.svh -----
// Assertion macros for the RTL of the modular exponentiation unit.
`ifndef RSA_MODEXP_DECRYPT_UNIT_DEFINES_SVH
`define RSA_MODEXP_DECRYPT_UNIT_DEFINES_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define RMD_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, checked on the rising clock edge outside reset.
`define RMD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ----- rtl/rmd_pkg.sv -----
// Shared constants for the modular exponentiation unit.
`timescale 1ns / 1ps

package rmd_pkg;

  // Width of ciphertext, plaintext, exponent and configuration data.
  localparam int unsigned WORD_BITS = 32;

  // Default width of the kept modulus.
  localparam int unsigned MOD_BITS_DEF = 32;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_BITS = 1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MODULUS  = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_EXPONENT = 1'b1;

endpackage

// ----- rtl/rmd_modmul.sv -----
// Bit-serial interleaved modular multiplier: one operand bit per cycle.
`timescale 1ns / 1ps

module rmd_modmul #(
  parameter int unsigned MOD_BITS = rmd_pkg::MOD_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [MOD_BITS-1:0]           a_i,
  input  logic [rmd_pkg::WORD_BITS-1:0] b_i,
  input  logic [MOD_BITS-1:0]           m_i,
  output logic                          busy_o,
  output logic                          done_o,
  output logic [MOD_BITS-1:0]           res_o
);

  localparam int unsigned CNT_BITS = $clog2(rmd_pkg::WORD_BITS);
  localparam int unsigned T_BITS   = MOD_BITS + 2;

  logic [MOD_BITS-1:0]           r_q, r_d;
  logic [MOD_BITS-1:0]           a_q;
  logic [rmd_pkg::WORD_BITS-1:0] b_q;
  logic [CNT_BITS-1:0]           cnt_q;
  logic                          busy_q;
  logic                          done_q;

  logic [T_BITS-1:0] t;
  logic [T_BITS-1:0] m1;
  logic [T_BITS-1:0] m2;

  // r stays below m and a is below m, so 2r + a stays below 3m.
  always_comb begin
    m1 = T_BITS'(m_i);
    m2 = m1 << 1;
    t  = (T_BITS'(r_q) << 1) + (b_q[rmd_pkg::WORD_BITS-1] ? T_BITS'(a_q) : '0);
    if (t >= m2) begin
      r_d = MOD_BITS'(t - m2);
    end else if (t >= m1) begin
      r_d = MOD_BITS'(t - m1);
    end else begin
      r_d = MOD_BITS'(t);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_BITS'(rmd_pkg::WORD_BITS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      r_q <= '0;
      a_q <= a_i;
      b_q <= b_i;
    end else if (busy_q) begin
      r_q <= r_d;
      b_q <= b_q << 1;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign res_o  = r_q;

endmodule

// ----- rtl/rsa_modexp_decrypt_unit.sv -----
// Top level: RSA decryption of one word, ciphertext^d mod n.
//
// Raise start for one cycle while busy is low to hand in a ciphertext word;
// busy stays high until the plaintext is out. The plaintext appears on
// plaintext_o for exactly one cycle, marked by plaintext_valid_o, and must be
// taken then. All arithmetic runs on one bit-serial modular multiplier. One word
// costs one product to reduce the ciphertext, one per set exponent bit and
// one square per exponent bit up to and including the highest set bit.
// A zero exponent costs one reduction, and a modulus below two gives 0 in
// the cycle after the start beat while busy stays low. Write the modulus and
// exponent only while busy is low.
`timescale 1ns / 1ps
`include "rsa_modexp_decrypt_unit_defines.svh"

module rsa_modexp_decrypt_unit #(
  parameter int unsigned MOD_BITS = rmd_pkg::MOD_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic [rmd_pkg::WORD_BITS-1:0]    ciphertext_i,
  output logic [rmd_pkg::WORD_BITS-1:0]    plaintext_o,
  output logic                             plaintext_valid_o,
  input  logic                             cfg_we_i,
  input  logic [rmd_pkg::CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [rmd_pkg::WORD_BITS-1:0]    cfg_data_i
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_STEP,
    S_WAIT
  } state_e;

  typedef enum logic [1:0] {
    OP_RED,
    OP_MUL,
    OP_SQR
  } op_e;

  state_e state_q;
  op_e    op_q;

  logic [MOD_BITS-1:0]           modulus_q;
  logic [rmd_pkg::WORD_BITS-1:0] exponent_q;
  logic [rmd_pkg::WORD_BITS-1:0] e_q;
  logic [MOD_BITS-1:0]           acc_q;
  logic [MOD_BITS-1:0]           base_q;
  logic                          mul_pend_q;
  logic                          mul_start_q;
  logic [MOD_BITS-1:0]           mul_a_q;
  logic [rmd_pkg::WORD_BITS-1:0] mul_b_q;
  logic [rmd_pkg::WORD_BITS-1:0] plaintext_q;
  logic                          valid_q;

  logic                mul_busy;
  logic                mul_done;
  logic [MOD_BITS-1:0] mul_res;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q  <= MOD_BITS'(2);
      exponent_q <= rmd_pkg::WORD_BITS'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rmd_pkg::CFG_MODULUS:  modulus_q  <= cfg_data_i[MOD_BITS-1:0];
        rmd_pkg::CFG_EXPONENT: exponent_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_RED;
      mul_start_q <= 1'b0;
      valid_q     <= 1'b0;
      mul_pend_q  <= 1'b0;
      e_q         <= '0;
      acc_q       <= '0;
      base_q      <= '0;
      mul_a_q     <= '0;
      mul_b_q     <= '0;
      plaintext_q <= '0;
    end else begin
      mul_start_q <= 1'b0;
      valid_q     <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start) begin
            if (modulus_q < MOD_BITS'(2)) begin
              plaintext_q <= '0;
              valid_q     <= 1'b1;
            end else begin
              // Reduce the ciphertext as 1 * c mod n.
              mul_a_q     <= MOD_BITS'(1);
              mul_b_q     <= ciphertext_i;
              mul_start_q <= 1'b1;
              op_q        <= OP_RED;
              e_q         <= exponent_q;
              acc_q       <= MOD_BITS'(1);
              mul_pend_q  <= 1'b0;
              state_q     <= S_WAIT;
            end
          end
        end
        S_STEP: begin
          if (e_q == '0) begin
            plaintext_q <= rmd_pkg::WORD_BITS'(acc_q);
            valid_q     <= 1'b1;
            state_q     <= S_IDLE;
          end else if (e_q[0] && !mul_pend_q) begin
            mul_a_q     <= acc_q;
            mul_b_q     <= rmd_pkg::WORD_BITS'(base_q);
            mul_start_q <= 1'b1;
            op_q        <= OP_MUL;
            state_q     <= S_WAIT;
          end else begin
            mul_a_q     <= base_q;
            mul_b_q     <= rmd_pkg::WORD_BITS'(base_q);
            mul_start_q <= 1'b1;
            op_q        <= OP_SQR;
            state_q     <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (mul_done) begin
            state_q <= S_STEP;
            case (op_q)
              OP_RED: base_q <= mul_res;
              OP_MUL: begin
                acc_q      <= mul_res;
                mul_pend_q <= 1'b1;
              end
              OP_SQR: begin
                // Advance to the next exponent bit.
                base_q     <= mul_res;
                e_q        <= e_q >> 1;
                mul_pend_q <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  rmd_modmul #(
    .MOD_BITS(MOD_BITS)
  ) u_modmul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_start_q),
    .a_i    (mul_a_q),
    .b_i    (mul_b_q),
    .m_i    (modulus_q),
    .busy_o (mul_busy),
    .done_o (mul_done),
    .res_o  (mul_res)
  );

  assign busy              = (state_q != S_IDLE);
  assign plaintext_o       = plaintext_q;
  assign plaintext_valid_o = valid_q;

  `RMD_ASSERT_NEXT(a_accept_acts, start && !busy, busy || plaintext_valid_o)
  `RMD_ASSERT_IMPL(a_done_in_wait, mul_done, state_q == S_WAIT)
  `RMD_ASSERT_IMPL(a_valid_unit_idle, plaintext_valid_o, !mul_busy && !mul_start_q)
  `RMD_ASSERT_IMPL(a_acc_reduced, state_q != S_IDLE, acc_q < modulus_q)

endmodule

// ----- verif/rmd_plaintext_checker.sv -----
// Checker for the modular exponentiation unit: predicts each plaintext word and compares it.
`timescale 1ns / 1ps

module rmd_plaintext_checker #(
  parameter int unsigned MOD_BITS = rmd_pkg::MOD_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic                             busy_i,
  input  logic [rmd_pkg::WORD_BITS-1:0]    ciphertext_i,
  input  logic [rmd_pkg::WORD_BITS-1:0]    plaintext_i,
  input  logic                             plaintext_valid_i,
  input  logic                             cfg_we_i,
  input  logic [rmd_pkg::CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [rmd_pkg::WORD_BITS-1:0]    cfg_data_i,
  output int unsigned                      mismatches_o,
  output int unsigned                      pending_o
);

  localparam logic [63:0] MODULUS_MASK = (64'd1 << MOD_BITS) - 64'd1;

  logic [rmd_pkg::WORD_BITS-1:0] key_modulus;
  logic [rmd_pkg::WORD_BITS-1:0] key_exponent;
  logic [rmd_pkg::WORD_BITS-1:0] expected_plaintext[$];
  logic [rmd_pkg::WORD_BITS-1:0] oldest_plaintext;
  int unsigned                   fail_count = 0;
  int unsigned                   pending_count = 0;

  assign mismatches_o = fail_count;
  assign pending_o    = pending_count;

  // Square-and-multiply over all exponent bits, products held in 64 bits.
  function automatic logic [rmd_pkg::WORD_BITS-1:0] predict_plaintext(
    input logic [rmd_pkg::WORD_BITS-1:0] word,
    input logic [rmd_pkg::WORD_BITS-1:0] expo,
    input logic [rmd_pkg::WORD_BITS-1:0] n
  );
    logic [63:0] acc;
    logic [63:0] power;
    logic [63:0] m;
    if (n < 2) return '0;
    m     = {32'd0, n};
    acc   = 64'd1;
    power = {32'd0, word} % m;
    for (int i = 0; i < rmd_pkg::WORD_BITS; i++) begin
      if (expo[i]) acc = (acc * power) % m;
      power = (power * power) % m;
    end
    return acc[rmd_pkg::WORD_BITS-1:0];
  endfunction

  task automatic report_mismatch(
    input string                         what,
    input logic [rmd_pkg::WORD_BITS-1:0] got,
    input logic [rmd_pkg::WORD_BITS-1:0] want
  );
    $display("[%0t] mismatch: %s: got %h, expected %h", $realtime, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_modulus  = 32'd2;
      key_exponent = 32'd1;
      expected_plaintext.delete();
      pending_count = 0;
    end else begin
      if (plaintext_valid_i !== 1'b0) begin
        if (expected_plaintext.size() == 0) begin
          report_mismatch("plaintext beat with no word pending", plaintext_i, '0);
        end else begin
          oldest_plaintext = expected_plaintext.pop_front();
          if (plaintext_i !== oldest_plaintext || plaintext_valid_i !== 1'b1)
            report_mismatch("plaintext", plaintext_i, oldest_plaintext);
        end
      end
      if (start_i === 1'b1 && busy_i === 1'b0)
        expected_plaintext.push_back(
          predict_plaintext(ciphertext_i, key_exponent, key_modulus));
      if (cfg_we_i === 1'b1) begin
        case (cfg_idx_i)
          rmd_pkg::CFG_MODULUS: begin
            key_modulus = rmd_pkg::WORD_BITS'({32'd0, cfg_data_i} & MODULUS_MASK);
          end
          rmd_pkg::CFG_EXPONENT: begin
            key_exponent = cfg_data_i;
          end
          default: begin
          end
        endcase
      end
      pending_count = expected_plaintext.size();
    end
  end

endmodule

// ----- verif/rsa_modexp_decrypt_unit_tb.sv -----
// Testbench top for the modular exponentiation unit: drives words and keys, gives the verdict.
`timescale 1ns / 1ps

module rsa_modexp_decrypt_unit_tb;

  localparam int unsigned MOD_BITS      = rmd_pkg::MOD_BITS_DEF;
  localparam int unsigned RANDOM_WORDS  = 600;
  localparam int unsigned SETTLE_CYCLES = 100;
  // Allow several times the worst-case time per word plus long gaps.
  localparam int unsigned CYCLE_LIMIT   = 8_000_000;

  logic                             clk_i;
  logic                             rst_ni;
  logic                             start;
  logic                             busy;
  logic [rmd_pkg::WORD_BITS-1:0]    ciphertext_i;
  logic [rmd_pkg::WORD_BITS-1:0]    plaintext_o;
  logic                             plaintext_valid_o;
  logic                             cfg_we_i;
  logic [rmd_pkg::CFG_IDX_BITS-1:0] cfg_idx_i;
  logic [rmd_pkg::WORD_BITS-1:0]    cfg_data_i;
  int unsigned                      mismatches;
  int unsigned                      pending;
  int unsigned                      words_sent = 0;

  rsa_modexp_decrypt_unit #(
    .MOD_BITS(MOD_BITS)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .ciphertext_i     (ciphertext_i),
    .plaintext_o      (plaintext_o),
    .plaintext_valid_o(plaintext_valid_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i)
  );

  rmd_plaintext_checker #(
    .MOD_BITS(MOD_BITS)
  ) u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start),
    .busy_i           (busy),
    .ciphertext_i     (ciphertext_i),
    .plaintext_i      (plaintext_o),
    .plaintext_valid_i(plaintext_valid_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .mismatches_o     (mismatches),
    .pending_o        (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("TEST FAILED");
    $finish;
  end

  // Hold start until the beat is taken; return on the following falling edge.
  task automatic send_word(input logic [rmd_pkg::WORD_BITS-1:0] word);
    start        <= 1'b1;
    ciphertext_i <= word;
    do @(posedge clk_i); while (busy !== 1'b0);
    @(negedge clk_i);
    words_sent++;
  endtask

  // Drop start and scramble the idle data bus; n >= 1 sets the length of the pause.
  task automatic pause(input int unsigned n);
    start        <= 1'b0;
    ciphertext_i <= $urandom();
    repeat (n) @(negedge clk_i);
  endtask

  task automatic drain();
    pause(1);
    while (pending != 0 || busy !== 1'b0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic load_key(input logic [rmd_pkg::WORD_BITS-1:0] n,
                          input logic [rmd_pkg::WORD_BITS-1:0] d);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= rmd_pkg::CFG_MODULUS;
    cfg_data_i <= n;
    @(negedge clk_i);
    cfg_idx_i  <= rmd_pkg::CFG_EXPONENT;
    cfg_data_i <= d;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    cfg_data_i <= $urandom();
  endtask

  function automatic logic [rmd_pkg::WORD_BITS-1:0] pick_word(
    input logic [rmd_pkg::WORD_BITS-1:0] n
  );
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 32'd1;
      2: return n - 32'd1;
      3: return n;
      4: return '1;
      5, 6: return (n != 0) ? $urandom() % n : $urandom();
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [rmd_pkg::WORD_BITS-1:0] pick_modulus();
    case ($urandom_range(0, 11))
      0: return rmd_pkg::WORD_BITS'($urandom_range(0, 1));
      1: return 32'd2;
      2: return '1;
      3: return rmd_pkg::WORD_BITS'($urandom_range(2, 255));
      4: return rmd_pkg::WORD_BITS'($urandom_range(256, 65535));
      5: return {1'b1, 31'($urandom())};
      default: return $urandom();
    endcase
  endfunction

  // Keep most exponents short so the run stays quick; a few span all 32 bits.
  function automatic logic [rmd_pkg::WORD_BITS-1:0] pick_exponent();
    case ($urandom_range(0, 15))
      0: return '0;
      1: return '1;
      2: return 32'd1;
      3: return 32'h8000_0000 | 32'($urandom_range(0, 3));
      4: return $urandom();
      5, 6: return rmd_pkg::WORD_BITS'($urandom_range(2, 16'hFFFF));
      default: return rmd_pkg::WORD_BITS'($urandom_range(2, 255));
    endcase
  endfunction

  // Bursts of words with random gaps; a long gap lands mid-computation.
  task automatic run_words(input int unsigned count,
                           input logic [rmd_pkg::WORD_BITS-1:0] n);
    int unsigned left;
    int unsigned burst;
    int unsigned gap;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 8);
      if (burst > left) burst = left;
      repeat (burst) send_word(pick_word(n));
      left -= burst;
      case ($urandom_range(0, 5))
        0: gap = 0;
        1: gap = $urandom_range(200, 2500);
        default: gap = $urandom_range(1, 4);
      endcase
      if (gap > 0) pause(gap);
    end
  endtask

  initial begin : stimulus
    int unsigned                   target;
    logic [rmd_pkg::WORD_BITS-1:0] n;
    rst_ni       = 1'b0;
    start        = 1'b0;
    ciphertext_i = '0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = rmd_pkg::CFG_MODULUS;
    cfg_data_i   = '0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset key: modulus 2, exponent 1.
    send_word('0);
    send_word(32'd1);
    send_word('1);
    drain();
    // Widest modulus and exponent: the slowest words.
    load_key('1, '1);
    send_word('1);
    send_word(32'hFFFF_FFFE);
    send_word('0);
    send_word(32'd1);
    drain();
    // Textbook key, including ciphertext at and above the modulus.
    load_key(32'd3233, 32'd2753);
    send_word(32'd855);
    send_word(32'd65);
    send_word(32'd3233);
    send_word(32'd3300);
    drain();
    // Zero exponent gives one.
    load_key(32'd65521, '0);
    send_word(32'd12345);
    send_word('0);
    drain();
    // Modulus below two gives zero.
    load_key('0, 32'h0000_1234);
    send_word(32'd7);
    send_word('1);
    drain();
    load_key(32'd1, '0);
    send_word('0);
    send_word(32'd5);
    drain();
    // Only the top exponent bit set.
    load_key(32'd2, 32'h8000_0000);
    send_word(32'd3);
    send_word(32'hFFFF_FFFE);
    drain();
    load_key(32'hFFFF_FFFB, 32'h0001_0001);
    send_word(32'hAAAA_AAAA);
    send_word(32'h5555_5555);
    drain();

    target = words_sent + RANDOM_WORDS;
    while (words_sent < target) begin
      n = pick_modulus();
      load_key(n, pick_exponent());
      run_words($urandom_range(8, 40), n);
      drain();
    end

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
